FILE: hw/rtl/utf8_to_utf16_decoder_unit_assert.svh
// Assertion macros for the UTF-8 to UTF-16 decoder.
// Each expects clk and rst_n in scope.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define U2U_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U2U_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/u2u_pkg.sv
package u2u_pkg;

    localparam int unsigned ACC_W     = 31;
    localparam int unsigned PEND_W    = 3;
    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned RES_IDX_W = 2;

    localparam logic [15:0]      BOM_CODE    = 16'hFEFF;
    localparam logic [15:0]      BOM_SWAPPED = 16'hFFFE;
    localparam logic [ACC_W-1:0] MAX_CODE    = 31'h10FFFF;
    localparam logic [ACC_W-1:0] BMP_MAX     = 31'h00FFFF;
    localparam logic [20:0]      SUPP_BASE   = 21'h10000;
    localparam logic [5:0]       HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]       LO_SURR_TAG = 6'b110111;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ENC_ERR    = 2'd1,
        ST_INCOMPLETE = 2'd2
    } u2u_status_t;

    typedef enum logic [0:0] {
        CFG_DROP_BOM = 1'b0,
        CFG_ADD_BOM  = 1'b1
    } u2u_cfg_idx_t;

    typedef struct packed {
        logic [15:0] unit;
        u2u_status_t status;
    } u2u_res_t;

endpackage

FILE: hw/rtl/u2u_ifs.sv
interface u2u_byte_if
    import u2u_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_input;

    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface u2u_unit_if
    import u2u_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    u2u_status_t status;
    logic        last_of_run;

    modport source (output valid, output code_unit, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input code_unit, input status, input last_of_run,
                    output ready);
endinterface

interface u2u_cfg_if
    import u2u_pkg::*;
();
    logic         valid;
    logic         ready;
    u2u_cfg_idx_t index;
    logic         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/utf8_to_utf16_decoder_unit.sv
// UTF-8 to UTF-16 decoder.
// byte_stream: one UTF-8 byte per item, end_of_input flags the last byte of a stream.
// unit_stream: one UTF-16 code unit or status per item; last_of_run marks the final
//   item caused by one input byte. A byte gives zero to three items.
// cfg: register 0 drops a leading byte order mark, register 1 inserts one before
//   the first character; always ready, write only while the block is idle.
// Path: a byte is held in the input register, decoded into the three-entry result
//   register, and its first item is offered from the result register.
// Throughput: one byte per cycle while each byte gives at most one item and the
//   receiver is ready; a byte giving n items occupies the result register until the
//   single output port drains it one item a cycle, while the receiver is ready.
// A stalled receiver holds the current item; the input register still takes one
//   more byte, then ready drops until the result register drains.
// Reset clears the decoder state, both registers and all pending items; the
//   next byte starts a new stream.
`include "utf8_to_utf16_decoder_unit_assert.svh"

module utf8_to_utf16_decoder_unit
    import u2u_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    u2u_byte_if.sink       byte_stream,
    u2u_unit_if.source     unit_stream,
    u2u_cfg_if.sink        cfg
);

    logic                 in_vld_reg;
    logic [7:0]           byte_reg;
    logic                 eoi_reg;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [PEND_W-1:0]    pend_reg, pend_next;
    logic                 fcs_reg, fcs_next;
    logic                 consume_reg;
    logic                 generate_reg;
    u2u_res_t             res_reg [MAX_RES];
    u2u_res_t             res_next [MAX_RES];
    logic [RES_IDX_W-1:0] cnt_reg, cnt_next;
    logic [RES_IDX_W-1:0] idx_reg;

    logic                 out_fire;
    logic                 out_last;
    logic                 buf_done;
    logic                 move;

    assign out_last = (idx_reg == cnt_reg - 2'd1);
    assign out_fire = unit_stream.valid && unit_stream.ready;
    assign buf_done = out_fire && out_last;
    assign move     = in_vld_reg && ((cnt_reg == '0) || buf_done);

    assign byte_stream.ready     = !in_vld_reg || move;
    assign cfg.ready             = 1'b1;
    assign unit_stream.valid     = (cnt_reg != '0);
    assign unit_stream.code_unit = res_reg[idx_reg].unit;
    assign unit_stream.status    = res_reg[idx_reg].status;
    assign unit_stream.last_of_run = out_last;

    always_comb
    begin
        logic [RES_IDX_W-1:0] k;
        logic                 emit;
        logic                 err;
        logic                 skip;
        logic [ACC_W-1:0]     cp;
        logic [ACC_W-1:0]     acc_shift;
        logic [20:0]          v;

        acc_next  = acc_reg;
        pend_next = pend_reg;
        fcs_next  = fcs_reg;
        k         = '0;
        emit      = 1'b0;
        err       = 1'b0;
        skip      = 1'b0;
        cp        = '0;
        v         = '0;
        acc_shift = {acc_reg[ACC_W-7:0], byte_reg[5:0]};
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = '{unit: 16'h0, status: ST_OK};
        end

        if (pend_reg == '0)
        begin
            if (!byte_reg[7])
            begin
                emit = 1'b1;
                cp   = {23'h0, byte_reg};
            end
            else if (!byte_reg[6] || (byte_reg[7:1] == 7'h7F))
            begin
                err = 1'b1;
            end
            else if (!byte_reg[5])
            begin
                acc_next  = {26'h0, byte_reg[4:0]};
                pend_next = 3'd1;
            end
            else if (!byte_reg[4])
            begin
                acc_next  = {27'h0, byte_reg[3:0]};
                pend_next = 3'd2;
            end
            else if (!byte_reg[3])
            begin
                acc_next  = {28'h0, byte_reg[2:0]};
                pend_next = 3'd3;
            end
            else if (!byte_reg[2])
            begin
                acc_next  = {29'h0, byte_reg[1:0]};
                pend_next = 3'd4;
            end
            else
            begin
                acc_next  = {30'h0, byte_reg[0]};
                pend_next = 3'd5;
            end
        end
        else if (byte_reg[7:6] == 2'b10)
        begin
            pend_next = pend_reg - 3'd1;
            if (pend_reg == 3'd1)
            begin
                emit     = 1'b1;
                cp       = acc_shift;
                acc_next = '0;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end
        else
        begin
            err       = 1'b1;
            acc_next  = '0;
            pend_next = '0;
        end

        if (err)
        begin
            res_next[k] = '{unit: 16'h0, status: ST_ENC_ERR};
            k = k + 2'd1;
        end

        if (emit)
        begin
            if (!fcs_reg)
            begin
                fcs_next = 1'b1;
                if ((cp == {15'h0, BOM_CODE}) || (cp == {15'h0, BOM_SWAPPED}))
                begin
                    skip = 1'b1;
                    if (!consume_reg)
                    begin
                        res_next[k] = '{unit: BOM_CODE, status: ST_OK};
                        k = k + 2'd1;
                    end
                end
                else if (generate_reg)
                begin
                    res_next[k] = '{unit: BOM_CODE, status: ST_OK};
                    k = k + 2'd1;
                end
            end
            if (!skip)
            begin
                v = cp[20:0] - SUPP_BASE;
                if (cp > MAX_CODE)
                begin
                    res_next[k] = '{unit: 16'h0, status: ST_ENC_ERR};
                    k = k + 2'd1;
                end
                else if (cp > BMP_MAX)
                begin
                    res_next[k] = '{unit: {HI_SURR_TAG, v[19:10]}, status: ST_OK};
                    k = k + 2'd1;
                    res_next[k] = '{unit: {LO_SURR_TAG, cp[9:0]}, status: ST_OK};
                    k = k + 2'd1;
                end
                else
                begin
                    res_next[k] = '{unit: cp[15:0], status: ST_OK};
                    k = k + 2'd1;
                end
            end
        end

        if (eoi_reg)
        begin
            if (pend_next != '0)
            begin
                res_next[k] = '{unit: 16'h0, status: ST_INCOMPLETE};
                k = k + 2'd1;
            end
            acc_next  = '0;
            pend_next = '0;
            fcs_next  = 1'b0;
        end

        cnt_next = k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            acc_reg      <= '0;
            pend_reg     <= '0;
            fcs_reg      <= 1'b0;
            consume_reg  <= 1'b0;
            generate_reg <= 1'b0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                in_vld_reg <= byte_stream.valid;
            end

            if (move)
            begin
                acc_reg  <= acc_next;
                pend_reg <= pend_next;
                fcs_reg  <= fcs_next;
                cnt_reg  <= cnt_next;
                idx_reg  <= '0;
            end
            else if (buf_done)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else if (out_fire)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_DROP_BOM: consume_reg  <= cfg.data;
                    CFG_ADD_BOM:  generate_reg <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            byte_reg <= byte_stream.byte_in;
            eoi_reg  <= byte_stream.end_of_input;
        end
        if (move)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    `U2U_ASSERT_NOW(a_idx_in_run, unit_stream.valid, idx_reg < cnt_reg,
        "result index beyond result count")
    `U2U_ASSERT_NOW(a_acc_clear_idle, pend_reg == '0, acc_reg == '0,
        "accumulator not clear with nothing pending")
    `U2U_ASSERT_NOW(a_pend_range, 1'b1, pend_reg <= 3'd5,
        "pending count out of range")
    `U2U_ASSERT_NEXT(a_run_kept, out_fire && !out_last, unit_stream.valid,
        "run of results cut short")
    `U2U_ASSERT_NOW(a_err_zero_unit, unit_stream.valid && (unit_stream.status != ST_OK),
        unit_stream.code_unit == 16'h0, "status item carries a non-zero unit")

endmodule
